### rtl/core/mle_pkg.sv
// Shared types, constants and the letter table for the Morse letter encoder.
package mle_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [DurW-1:0] DotReset = 16'd75;
  localparam logic [DurW-1:0] DashReset = 16'd150;
  localparam logic [DurW-1:0] ElemGapReset = 16'd500;
  localparam logic [DurW-1:0] LetterGapReset = 16'd1750;
  localparam logic [DurW-1:0] SpaceGapReset = 16'd300;
  localparam logic [DurW-1:0] EmptyGapReset = 16'd1;

  localparam logic [CharW-1:0] CharEmpty = 8'h00;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharA = 8'h41;
  localparam logic [CharW-1:0] CharZ = 8'h5A;

  typedef enum logic [2:0] {
    REG_DOT       = 3'd0,
    REG_DASH      = 3'd1,
    REG_ELEM_GAP  = 3'd2,
    REG_LETTER_GAP = 3'd3,
    REG_SPACE_GAP = 3'd4,
    REG_EMPTY_GAP = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_SPACE  = 2'd1,
    KIND_EMPTY  = 2'd2
  } char_kind_t;

  // seg_cnt of zero means the character yields nothing
  typedef struct packed {
    char_kind_t kind;
    logic [3:0] seg_cnt;
    logic [3:0] pat;     // first element in bit 3, 1 = dash
  } char_desc_t;

  // High nibble: element count, low nibble: pattern, first element in top used bit.
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:  code = 8'h21;
      5'd1:  code = 8'h48;
      5'd2:  code = 8'h4A;
      5'd3:  code = 8'h34;
      5'd4:  code = 8'h10;
      5'd5:  code = 8'h42;
      5'd6:  code = 8'h36;
      5'd7:  code = 8'h40;
      5'd8:  code = 8'h20;
      5'd9:  code = 8'h47;
      5'd10: code = 8'h35;
      5'd11: code = 8'h44;
      5'd12: code = 8'h23;
      5'd13: code = 8'h22;
      5'd14: code = 8'h37;
      5'd15: code = 8'h46;
      5'd16: code = 8'h4D;
      5'd17: code = 8'h32;
      5'd18: code = 8'h30;
      5'd19: code = 8'h11;
      5'd20: code = 8'h31;
      5'd21: code = 8'h41;
      5'd22: code = 8'h33;
      5'd23: code = 8'h49;
      5'd24: code = 8'h4B;
      5'd25: code = 8'h4C;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic char_desc_t decode_char(input logic [CharW-1:0] c);
    char_desc_t d;
    logic [7:0] code;
    logic [CharW-1:0] off;
    off = c - CharA;
    code = letter_code(off[4:0]);
    d.kind = KIND_LETTER;
    d.seg_cnt = 4'd0;
    d.pat = 4'd0;
    if (c == CharEmpty) begin
      d.kind = KIND_EMPTY;
      d.seg_cnt = 4'd1;
    end else if (c == CharSpace) begin
      d.kind = KIND_SPACE;
      d.seg_cnt = 4'd1;
    end else if (c >= CharA && c <= CharZ) begin
      d.seg_cnt = {code[6:4], 1'b0};
      // left-align the pattern so element e sits at bit 3-e
      case (code[6:4])
        3'd1:    d.pat = {code[0], 3'b000};
        3'd2:    d.pat = {code[1:0], 2'b00};
        3'd3:    d.pat = {code[2:0], 1'b0};
        3'd4:    d.pat = code[3:0];
        default: d.pat = 4'd0;
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/core/morse_letter_encoder_unit.sv
// Morse letter encoder: turns character beats into timed tone and gap segment beats.
// Each accepted character yields its segments one per cycle on the output stream, held while
// the receiver stalls: a letter of n elements yields 2n segments (2 to 8), a space or an empty
// code yields one, and any other code is taken and gives no beat. The segment counter over the
// held character counts them; the next character is taken in the cycle its final segment
// moves into the output register, so characters follow back to back. Output tdata is the
// duration in ticks, tuser is the tone flag and tlast marks a character's final segment.
// Durations come from six 16-bit registers on the APB port at byte addresses 0 to 20.
module morse_letter_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  // segment stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] duration
  output logic        m_axis_tuser,   // [0] tone_on
  output logic        m_axis_tlast
);

  logic [15:0] dot_ticks;
  logic [15:0] dash_ticks;
  logic [15:0] elem_gap_ticks;
  logic [15:0] letter_gap_ticks;
  logic [15:0] space_gap_ticks;
  logic [15:0] empty_gap_ticks;

  logic busy;
  logic busy_next;
  logic [2:0] idx;
  logic [2:0] idx_next;
  mle_pkg::char_desc_t desc;
  mle_pkg::char_desc_t in_desc;

  logic out_free;
  logic emit;
  logic seg_final;
  logic accept;
  logic cfg_wr;
  mle_pkg::reg_idx_t cfg_idx;

  logic seg_tone;
  logic [15:0] seg_dur;
  logic [1:0] elem;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign cfg_idx = mle_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      mle_pkg::REG_DOT:        prdata = {16'd0, dot_ticks};
      mle_pkg::REG_DASH:       prdata = {16'd0, dash_ticks};
      mle_pkg::REG_ELEM_GAP:   prdata = {16'd0, elem_gap_ticks};
      mle_pkg::REG_LETTER_GAP: prdata = {16'd0, letter_gap_ticks};
      mle_pkg::REG_SPACE_GAP:  prdata = {16'd0, space_gap_ticks};
      mle_pkg::REG_EMPTY_GAP:  prdata = {16'd0, empty_gap_ticks};
      default:                 prdata = 32'd0;
    endcase
  end

  assign in_desc = mle_pkg::decode_char(s_axis_tdata);
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign emit = busy & out_free;
  assign seg_final = ({1'b0, idx} + 4'd1) == desc.seg_cnt;
  assign s_axis_tready = ~busy | (emit & seg_final);
  assign accept = s_axis_tvalid & s_axis_tready;
  assign elem = idx[2:1];

  // even index: tone of element idx/2, odd index: the gap after it
  always_comb begin
    seg_tone = 1'b0;
    seg_dur = empty_gap_ticks;
    case (desc.kind)
      mle_pkg::KIND_LETTER: begin
        if (!idx[0]) begin
          seg_tone = 1'b1;
          seg_dur = desc.pat[2'd3 - elem] ? dash_ticks : dot_ticks;
        end else begin
          seg_dur = seg_final ? letter_gap_ticks : elem_gap_ticks;
        end
      end
      mle_pkg::KIND_SPACE: seg_dur = space_gap_ticks;
      mle_pkg::KIND_EMPTY: seg_dur = empty_gap_ticks;
      default:             seg_dur = empty_gap_ticks;
    endcase
  end

  always_comb begin
    busy_next = busy;
    idx_next = idx;
    if (emit) begin
      idx_next = idx + 3'd1;
      if (seg_final) begin
        busy_next = 1'b0;
      end
    end
    if (accept) begin
      busy_next = in_desc.seg_cnt != 4'd0;
      idx_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 3'd0;
      m_axis_tvalid <= 1'b0;
      dot_ticks <= mle_pkg::DotReset;
      dash_ticks <= mle_pkg::DashReset;
      elem_gap_ticks <= mle_pkg::ElemGapReset;
      letter_gap_ticks <= mle_pkg::LetterGapReset;
      space_gap_ticks <= mle_pkg::SpaceGapReset;
      empty_gap_ticks <= mle_pkg::EmptyGapReset;
    end else begin
      busy <= busy_next;
      idx <= idx_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          mle_pkg::REG_DOT:        dot_ticks <= pwdata[15:0];
          mle_pkg::REG_DASH:       dash_ticks <= pwdata[15:0];
          mle_pkg::REG_ELEM_GAP:   elem_gap_ticks <= pwdata[15:0];
          mle_pkg::REG_LETTER_GAP: letter_gap_ticks <= pwdata[15:0];
          mle_pkg::REG_SPACE_GAP:  space_gap_ticks <= pwdata[15:0];
          mle_pkg::REG_EMPTY_GAP:  empty_gap_ticks <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload: descriptor and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= in_desc;
    end
    if (emit) begin
      m_axis_tdata <= seg_dur;
      m_axis_tuser <= seg_tone;
      m_axis_tlast <= seg_final;
    end
  end

`ifndef SYNTHESIS
  // the final segment of a character is always silent
  a_last_silent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("final segment carries tone");

  // the segment counter stays inside the held character
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < desc.seg_cnt))
    else $error("segment index beyond character");

  // a tone segment is always followed by a gap of the same character
  a_tone_then_gap: assert property (@(posedge clk) disable iff (rst)
    emit && seg_tone |=> busy && idx[0])
    else $error("tone segment not followed by gap");

  // no new character while an unfinished one is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    busy && !(emit && seg_final) |-> !s_axis_tready)
    else $error("input taken mid-character");
`endif

endmodule

### tb/morse_letter_encoder_unit_tb.sv
// Self-checking testbench for the Morse letter encoder: character stream in, segment stream out.
`timescale 1ns / 100ps

module morse_letter_encoder_unit_tb;

  localparam int DurW = mle_pkg::DurW;
  localparam int CharW = mle_pkg::CharW;
  localparam int AddrW = mle_pkg::AddrW;
  localparam int DataW = mle_pkg::DataW;

  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_CHARS = 73;

  typedef struct packed {
    logic            tone;
    logic [DurW-1:0] ticks;
    logic            fin;
  } segment_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DurW-1:0]  m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  logic [DurW-1:0]  tick_reg [0:5];
  logic [CharW-1:0] char_pending_q [$];
  segment_t         segment_expect_q [$];
  logic             char_taken = 1'b0;
  bit               send_idle_on = 1'b0;
  bit               recv_idle_on = 1'b0;
  int               send_gap = 0;
  int               recv_stall = 0;
  int               quiet_cycles = 0;
  int               mismatch_count = 0;

  morse_letter_encoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Dots and dashes of a letter, first element first.
  function automatic string morse_marks(input logic [CharW-1:0] c);
    case (c)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      default: return "";
    endcase
  endfunction

  function automatic void queue_segments(input logic [CharW-1:0] c);
    string marks;
    int    i;
    logic  fin;
    if (c == mle_pkg::CharEmpty) begin
      segment_expect_q.push_back({1'b0, tick_reg[mle_pkg::REG_EMPTY_GAP], 1'b1});
    end else if (c == mle_pkg::CharSpace) begin
      segment_expect_q.push_back({1'b0, tick_reg[mle_pkg::REG_SPACE_GAP], 1'b1});
    end else if (c >= mle_pkg::CharA && c <= mle_pkg::CharZ) begin
      marks = morse_marks(c);
      for (i = 0; i < marks.len(); i++) begin
        fin = (i == marks.len() - 1);
        segment_expect_q.push_back({1'b1,
            (marks[i] == "-") ? tick_reg[mle_pkg::REG_DASH] : tick_reg[mle_pkg::REG_DOT],
            1'b0});
        segment_expect_q.push_back({1'b0,
            fin ? tick_reg[mle_pkg::REG_LETTER_GAP] : tick_reg[mle_pkg::REG_ELEM_GAP], fin});
      end
    end
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = mle_pkg::CharSpace;
      1:       c = mle_pkg::CharEmpty;
      2, 3:    c = CharW'($urandom_range(0, 255));
      default: c = mle_pkg::CharA + CharW'($urandom_range(0, 25));
    endcase
    return c;
  endfunction

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DurW-1:0] val);
    logic [DurW-1:0] junk;
    junk = DurW'($urandom);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = {junk, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // indexes past the last register are ignored
    if (addr[4:2] <= mle_pkg::REG_EMPTY_GAP) tick_reg[addr[4:2]] = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_ticks(input logic [DurW-1:0] dot, input logic [DurW-1:0] dash,
                               input logic [DurW-1:0] egap, input logic [DurW-1:0] lgap,
                               input logic [DurW-1:0] sgap, input logic [DurW-1:0] mgap);
    apb_write({mle_pkg::REG_DOT, 2'b00}, dot);
    apb_write({mle_pkg::REG_DASH, 2'b00}, dash);
    apb_write({mle_pkg::REG_ELEM_GAP, 2'b00}, egap);
    apb_write({mle_pkg::REG_LETTER_GAP, 2'b00}, lgap);
    apb_write({mle_pkg::REG_SPACE_GAP, 2'b00}, sgap);
    apb_write({mle_pkg::REG_EMPTY_GAP, 2'b00}, mgap);
  endtask

  // Hold off until every character is taken and every segment has come back.
  task automatic drain_segments();
    while (char_pending_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (segment_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || char_taken) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (char_pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= $urandom_range(0, 17);
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= char_pending_q.pop_front();
      end
    end
  end

  always @(negedge clk) begin
    if (recv_stall != 0) begin
      m_axis_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (recv_idle_on && $urandom_range(0, 6) == 0) begin
      m_axis_tready <= 1'b0;
      recv_stall <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    segment_t seg;
    char_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) queue_segments(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (segment_expect_q.size() == 0) begin
          $display("%0t: segment beat with none expected, actual tone %0b duration %0d last %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          seg = segment_expect_q.pop_front();
          if (m_axis_tuser !== seg.tone) begin
            $display("%0t: tone_on mismatch, expected %0b, actual %0b",
                     $time, seg.tone, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata !== seg.ticks) begin
            $display("%0t: duration mismatch, expected %0d, actual %0d",
                     $time, seg.ticks, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== seg.fin) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, seg.fin, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CharW-1:0] directed [$];
    int ph;
    int i;
    tick_reg[mle_pkg::REG_DOT] = mle_pkg::DotReset;
    tick_reg[mle_pkg::REG_DASH] = mle_pkg::DashReset;
    tick_reg[mle_pkg::REG_ELEM_GAP] = mle_pkg::ElemGapReset;
    tick_reg[mle_pkg::REG_LETTER_GAP] = mle_pkg::LetterGapReset;
    tick_reg[mle_pkg::REG_SPACE_GAP] = mle_pkg::SpaceGapReset;
    tick_reg[mle_pkg::REG_EMPTY_GAP] = mle_pkg::EmptyGapReset;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty and space, letters of every length and both ends of the
    // alphabet, then codes just outside the handled ranges and the top bit.
    directed = '{mle_pkg::CharEmpty, mle_pkg::CharSpace, "A", "E", "T", "M", "S", "O", "H",
                 "Q", "B", mle_pkg::CharZ, 8'h40, 8'h5B, 8'h61, 8'h30, 8'h1F, 8'h21, 8'h7F,
                 8'h80, 8'hFF, mle_pkg::CharEmpty, mle_pkg::CharSpace};
    @(posedge clk);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    foreach (directed[k]) char_pending_q.push_back(directed[k]);
    drain_segments();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_ticks(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        1: program_ticks(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: begin
          program_ticks(16'd0, DurW'($urandom_range(1, 65535)),
                        DurW'($urandom_range(1, 65535)), DurW'($urandom_range(1, 65535)),
                        DurW'($urandom_range(1, 65535)), 16'd0);
          // addresses past the register file must leave every register alone
          apb_write(5'd24, DurW'($urandom));
          apb_write(5'd28, DurW'($urandom));
        end
        default: program_ticks(DurW'($urandom_range(1, 65535)),
                               DurW'($urandom_range(1, 65535)),
                               DurW'($urandom_range(1, 65535)),
                               DurW'($urandom_range(1, 65535)),
                               DurW'($urandom_range(1, 65535)),
                               DurW'($urandom_range(1, 65535)));
      endcase
      @(posedge clk);
      send_idle_on = (ph != 2) && (ph != 5);
      recv_idle_on = (ph != 1) && (ph != 5);
      for (i = 0; i < RANDOM_CHARS; i++) char_pending_q.push_back(pick_char());
      drain_segments();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
